FILE: rtl/core/gecd_pkg.sv
`default_nettype none

package gecd_pkg;

	// Line store depth and the widest row the block handles.
	localparam int MAX_WIDTH    = 64;
	localparam int MAX_CHANNELS = 4;
	localparam int HEIGHT_LIMIT = 1024;

	localparam int SAMPLE_BITS = 8;
	localparam int PIXEL_BITS  = MAX_CHANNELS * SAMPLE_BITS;
	localparam int WIDTH_BITS  = 7;
	localparam int HEIGHT_BITS = 11;
	localparam int CHAN_BITS   = 3;
	localparam int IDX_BITS    = 18;
	localparam int VAL_BITS    = 18;
	localparam int SQ_BITS     = 2 * SAMPLE_BITS;
	localparam int COL_BITS    = $clog2(MAX_WIDTH);
	localparam int ROW_BITS    = $clog2(HEIGHT_LIMIT);

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 11;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNELS = 2'd2;

	typedef logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] pixel_t;

	typedef enum logic [1:0] {
		KIND_RIGHT      = 2'd0,
		KIND_DOWN_LEFT  = 2'd1,
		KIND_DOWN       = 2'd2,
		KIND_DOWN_RIGHT = 2'd3
	} edge_kind_t;

	// Position flags of a pixel, captured when it is accepted.
	typedef struct packed {
		logic has_up;
		logic has_left;
		logic has_up_right;
		logic next_last_col;
		logic last_row;
	} edge_ctx_t;

endpackage

`default_nettype wire

FILE: rtl/core/grid_edge_color_difference.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// pixel     in         pixel_valid/pixel_stall   chan_0 .. chan_3
// feature   out        feature_valid/feature_stall
//                                                feature_index, edge_kind,
//                                                feature_value, last_in_run,
//                                                image_done
// config    in         cfg_write                 cfg_index, cfg_data
//
// A pixel completes a feature per edge to a left, upper-left, upper or
// upper-right neighbor, and none when it is the first pixel of an image.
// The single output register takes one feature per cycle while the
// feature side does not stall. The next pixel is taken in the cycle in
// which the last feature of the current one moves to the output register.
// Reset clears the position counters and all valid state; the line store
// needs no clearing since row zero fills it before it is read.
// A stall on the feature side holds the output register and stalls the
// pixel side while the pending pixel still has a feature left to send; one
// more pixel is taken once the pending pixel has none.

module grid_edge_color_difference (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,

	input  wire logic                                  cfg_write,
	input  wire logic [gecd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [gecd_pkg::CFG_DATA_BITS-1:0]    cfg_data,

	input  wire logic                                  pixel_valid,
	output logic                                       pixel_stall,
	input  wire logic [gecd_pkg::SAMPLE_BITS-1:0]      chan_0,
	input  wire logic [gecd_pkg::SAMPLE_BITS-1:0]      chan_1,
	input  wire logic [gecd_pkg::SAMPLE_BITS-1:0]      chan_2,
	input  wire logic [gecd_pkg::SAMPLE_BITS-1:0]      chan_3,

	output logic                                       feature_valid,
	input  wire logic                                  feature_stall,
	output logic      [gecd_pkg::IDX_BITS-1:0]         feature_index,
	output logic      [1:0]                            edge_kind,
	output logic      [gecd_pkg::VAL_BITS-1:0]         feature_value,
	output logic                                       last_in_run,
	output logic                                       image_done
);

	// Configuration, held already saturated to the supported ranges.
	logic [gecd_pkg::WIDTH_BITS-1:0]  width_q;
	logic [gecd_pkg::HEIGHT_BITS-1:0] height_q;
	logic [gecd_pkg::CHAN_BITS-1:0]   chans_q;

	logic [gecd_pkg::WIDTH_BITS-1:0]  width_sat;
	logic [gecd_pkg::HEIGHT_BITS-1:0] height_sat;
	logic [gecd_pkg::CHAN_BITS-1:0]   chans_sat;

	always_comb begin
		width_sat = cfg_data[gecd_pkg::WIDTH_BITS-1:0];
		if (width_sat < gecd_pkg::WIDTH_BITS'(2)) begin
			width_sat = gecd_pkg::WIDTH_BITS'(2);
		end else if (width_sat > gecd_pkg::WIDTH_BITS'(gecd_pkg::MAX_WIDTH)) begin
			width_sat = gecd_pkg::WIDTH_BITS'(gecd_pkg::MAX_WIDTH);
		end
		height_sat = cfg_data[gecd_pkg::HEIGHT_BITS-1:0];
		if (height_sat < gecd_pkg::HEIGHT_BITS'(2)) begin
			height_sat = gecd_pkg::HEIGHT_BITS'(2);
		end else if (height_sat > gecd_pkg::HEIGHT_BITS'(gecd_pkg::HEIGHT_LIMIT)) begin
			height_sat = gecd_pkg::HEIGHT_BITS'(gecd_pkg::HEIGHT_LIMIT);
		end
		chans_sat = cfg_data[gecd_pkg::CHAN_BITS-1:0];
		if (chans_sat < gecd_pkg::CHAN_BITS'(1)) begin
			chans_sat = gecd_pkg::CHAN_BITS'(1);
		end else if (chans_sat > gecd_pkg::CHAN_BITS'(gecd_pkg::MAX_CHANNELS)) begin
			chans_sat = gecd_pkg::CHAN_BITS'(gecd_pkg::MAX_CHANNELS);
		end
	end

	logic cfg_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gecd_pkg::WIDTH_BITS'(64);
			height_q <= gecd_pkg::HEIGHT_BITS'(64);
			chans_q  <= gecd_pkg::CHAN_BITS'(3);
		end else if (cfg_write) begin
			unique case (cfg_index)
				gecd_pkg::CFG_WIDTH:    width_q  <= width_sat;
				gecd_pkg::CFG_HEIGHT:   height_q <= height_sat;
				gecd_pkg::CFG_CHANNELS: chans_q  <= chans_sat;
				default: ;
			endcase
		end
	end

	// Any write to a listed register restarts the image at the next pixel.
	always_comb begin
		unique case (cfg_index)
			gecd_pkg::CFG_WIDTH, gecd_pkg::CFG_HEIGHT, gecd_pkg::CFG_CHANNELS: begin
				cfg_hit = cfg_write;
			end
			default: begin
				cfg_hit = 1'b0;
			end
		endcase
	end

	// Position of the next pixel, and the packed-vector offset of its row.
	logic [gecd_pkg::COL_BITS-1:0] col_q;
	logic [gecd_pkg::ROW_BITS-1:0] row_q;
	logic [gecd_pkg::IDX_BITS-1:0] row_base_q;
	logic [gecd_pkg::IDX_BITS-1:0] stride;

	logic accept;
	logic last_col;
	logic next_last_col;
	logic last_row;

	// Each full row other than the last takes 4W-3 slots.
	assign stride        = gecd_pkg::IDX_BITS'({width_q, 2'b00}) - gecd_pkg::IDX_BITS'(3);
	assign last_col      = gecd_pkg::WIDTH_BITS'(col_q) + gecd_pkg::WIDTH_BITS'(1) == width_q;
	assign next_last_col = gecd_pkg::WIDTH_BITS'(col_q) + gecd_pkg::WIDTH_BITS'(2) == width_q;
	assign last_row      = gecd_pkg::HEIGHT_BITS'(row_q) + gecd_pkg::HEIGHT_BITS'(1) == height_q;
	assign accept        = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			row_base_q <= '0;
		end else if (cfg_hit) begin
			col_q      <= '0;
			row_q      <= '0;
			row_base_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q      <= '0;
					row_base_q <= '0;
				end else begin
					row_q      <= row_q + gecd_pkg::ROW_BITS'(1);
					row_base_q <= row_base_q + stride;
				end
			end else begin
				col_q <= col_q + gecd_pkg::COL_BITS'(1);
			end
		end
	end

	// Line store: the pixel above and the one above-right are read as the
	// pixel is accepted, while the pixel itself replaces the entry above.
	gecd_pkg::pixel_t pixel_in;
	gecd_pkg::pixel_t up_rd;
	gecd_pkg::pixel_t up_right_rd;

	assign pixel_in = gecd_pkg::pixel_t'({chan_3, chan_2, chan_1, chan_0});

	gecd_ram #(
		.WIDTH (gecd_pkg::PIXEL_BITS),
		.DEPTH (gecd_pkg::MAX_WIDTH)
	) u_line_store (
		.clk       (clk),
		.wr_en     (accept),
		.wr_addr   (col_q),
		.wr_data   (pixel_in),
		.rd_en     (accept),
		.rd_addr_a (col_q),
		.rd_addr_b (col_q + gecd_pkg::COL_BITS'(1)),
		.rd_data_a (up_rd),
		.rd_data_b (up_right_rd)
	);

	// Stage one: the pixel being turned into features, with its neighbors.
	// The above and above-right pixels stay in the store's read register.
	// The mask has one bit per pending edge kind; the highest goes first.
	gecd_pkg::pixel_t               pix_s1;
	gecd_pkg::pixel_t               left_s1;
	gecd_pkg::pixel_t               up_left_s1;
	gecd_pkg::edge_ctx_t            ctx_s1;
	logic [gecd_pkg::COL_BITS-1:0]  col_s1;
	logic [gecd_pkg::IDX_BITS-1:0]  base_prev_s1;
	logic [gecd_pkg::IDX_BITS-1:0]  base_cur_s1;
	logic                           done_s1;
	logic [3:0]                     mask_s1;

	gecd_pkg::edge_ctx_t ctx_in;
	logic [3:0]          mask_in;

	always_comb begin
		ctx_in.has_up        = row_q != '0;
		ctx_in.has_left      = col_q != '0;
		ctx_in.has_up_right  = !last_col;
		ctx_in.next_last_col = next_last_col;
		ctx_in.last_row      = last_row;
		mask_in = {ctx_in.has_up && ctx_in.has_left, ctx_in.has_up,
			ctx_in.has_up && ctx_in.has_up_right, ctx_in.has_left};
	end

	// The previous pixel and the entry read above it become the left and
	// upper-left neighbors of the new pixel.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= pixel_in;
			left_s1      <= pix_s1;
			up_left_s1   <= up_rd;
			ctx_s1       <= ctx_in;
			col_s1       <= col_q;
			base_prev_s1 <= row_base_q - stride;
			base_cur_s1  <= row_base_q;
			done_s1      <= last_col && last_row;
		end
	end

	// Pick the next edge of the pending pixel.
	gecd_pkg::edge_kind_t kind;
	gecd_pkg::pixel_t     partner;
	logic [3:0]           sel;
	logic [3:0]           rest;
	logic                 run_end;
	logic                 out_load;

	always_comb begin
		if (mask_s1[3]) begin
			kind = gecd_pkg::KIND_DOWN_RIGHT;
		end else if (mask_s1[2]) begin
			kind = gecd_pkg::KIND_DOWN;
		end else if (mask_s1[1]) begin
			kind = gecd_pkg::KIND_DOWN_LEFT;
		end else begin
			kind = gecd_pkg::KIND_RIGHT;
		end
		sel     = 4'b0001 << kind;
		rest    = mask_s1 & ~sel;
		run_end = rest == 4'b0000;
		case (kind)
			gecd_pkg::KIND_DOWN_RIGHT: partner = up_left_s1;
			gecd_pkg::KIND_DOWN:       partner = up_rd;
			gecd_pkg::KIND_DOWN_LEFT:  partner = up_right_rd;
			default:                   partner = left_s1;
		endcase
	end

	assign out_load    = (mask_s1 != 4'b0000) && (!feature_valid || !feature_stall);
	assign pixel_stall = (mask_s1 != 4'b0000) && !(out_load && run_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s1 <= '0;
		end else if (accept) begin
			mask_s1 <= mask_in;
		end else if (out_load) begin
			mask_s1 <= rest;
		end
	end

	logic [gecd_pkg::VAL_BITS-1:0] value_nx;
	logic [gecd_pkg::IDX_BITS-1:0] index_nx;

	gecd_sqdiff u_sqdiff (
		.pix_a (partner),
		.pix_b (pix_s1),
		.chans (chans_q),
		.value (value_nx)
	);

	gecd_index u_index (
		.ctx       (ctx_s1),
		.kind      (kind),
		.col       (col_s1),
		.base_prev (base_prev_s1),
		.base_cur  (base_cur_s1),
		.index     (index_nx)
	);

	// Output register.
	logic                          valid_q;
	logic [gecd_pkg::IDX_BITS-1:0] index_q;
	logic [1:0]                    kind_q;
	logic [gecd_pkg::VAL_BITS-1:0] value_q;
	logic                          run_end_q;
	logic                          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_load) begin
			valid_q <= 1'b1;
		end else if (!feature_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			index_q   <= index_nx;
			kind_q    <= kind;
			value_q   <= value_nx;
			run_end_q <= run_end;
			done_q    <= run_end && done_s1;
		end
	end

	assign feature_valid = valid_q;
	assign feature_index = index_q;
	assign edge_kind     = kind_q;
	assign feature_value = value_q;
	assign last_in_run   = run_end_q;
	assign image_done    = done_q;

	// The end of an image always closes a run.
	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		feature_valid && image_done |-> last_in_run)
		else $error("image end without run end");

	// The first pixel of an image completes no edge.
	a_first_pixel_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_hit && col_q == '0 && row_q == '0 |=> mask_s1 == 4'b0000)
		else $error("first pixel of an image produced features");

	// The column counter stays inside the row in use.
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		gecd_pkg::WIDTH_BITS'(col_q) < width_q)
		else $error("column counter beyond image width");

	// The running row offset tracks the row counter.
	a_row_base: assert property (@(posedge clk) disable iff (!arst_n)
		row_base_q == gecd_pkg::IDX_BITS'(row_q * stride))
		else $error("row offset out of step with row counter");

endmodule

`default_nettype wire

FILE: rtl/core/gecd_ram.sv
`default_nettype none

module gecd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic      [WIDTH-1:0]         rd_data_a,
	output logic      [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read-first: a read at the write address returns the old word.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/gecd_sqdiff.sv
`default_nettype none

module gecd_sqdiff (
	input  wire gecd_pkg::pixel_t                     pix_a,
	input  wire gecd_pkg::pixel_t                     pix_b,
	input  wire logic [gecd_pkg::CHAN_BITS-1:0]       chans,
	output logic      [gecd_pkg::VAL_BITS-1:0]        value
);

	logic [gecd_pkg::SQ_BITS-1:0] sq [gecd_pkg::MAX_CHANNELS];

	for (genvar c = 0; c < gecd_pkg::MAX_CHANNELS; c++) begin : g_chan
		logic signed [gecd_pkg::SAMPLE_BITS:0]     diff;
		logic signed [2*gecd_pkg::SAMPLE_BITS+1:0] prod;
		assign diff = $signed({1'b0, pix_a[c]}) - $signed({1'b0, pix_b[c]});
		assign prod = diff * diff;
		// The square of a byte difference fits in twice the sample width.
		assign sq[c] = prod[gecd_pkg::SQ_BITS-1:0];
	end

	always_comb begin
		value = '0;
		for (int c = 0; c < gecd_pkg::MAX_CHANNELS; c++) begin
			if (gecd_pkg::CHAN_BITS'(c) < chans) begin
				value = value + gecd_pkg::VAL_BITS'(sq[c]);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/gecd_index.sv
`default_nettype none

module gecd_index (
	input  wire gecd_pkg::edge_ctx_t               ctx,
	input  wire gecd_pkg::edge_kind_t              kind,
	input  wire logic [gecd_pkg::COL_BITS-1:0]     col,
	input  wire logic [gecd_pkg::IDX_BITS-1:0]     base_prev,
	input  wire logic [gecd_pkg::IDX_BITS-1:0]     base_cur,
	output logic      [gecd_pkg::IDX_BITS-1:0]     index
);

	logic [gecd_pkg::IDX_BITS-1:0] col_x;
	logic [gecd_pkg::IDX_BITS-1:0] col4;

	assign col_x = gecd_pkg::IDX_BITS'(col);
	assign col4  = col_x << 2;

	// Edges from the upper row land in that row's block of four slots per
	// column; the first column has no down-left slot and the last column
	// has only down-left and down. The bottom row holds right edges only.
	always_comb begin
		case (kind)
			gecd_pkg::KIND_DOWN_RIGHT: begin
				index = base_prev + col4 - 18'd2;
			end
			gecd_pkg::KIND_DOWN: begin
				index = base_prev + col4 + 18'd1 - {17'd0, ~ctx.has_up_right};
			end
			gecd_pkg::KIND_DOWN_LEFT: begin
				index = base_prev + col4 + 18'd4 - {17'd0, ctx.next_last_col};
			end
			default: begin
				if (ctx.last_row) begin
					index = base_cur + col_x - 18'd1;
				end else if (col_x == 18'd1) begin
					index = base_cur;
				end else begin
					index = base_cur + col4 - 18'd5;
				end
			end
		endcase
	end

endmodule

`default_nettype wire
